[rtl/gha_pkg.sv]
// Shared types and constants for the generational handle allocator.
// Used by gha_stack and generational_handle_allocator; no dependencies.
`default_nettype none

package gha_pkg;

  // Fixed field widths of the request and response words
  localparam int ACT_W   = 2;
  localparam int HIDX_W  = 16;
  localparam int GEN_W   = 32;
  localparam int LIVE_W  = 11;
  localparam int IN_W    = 56;
  localparam int OUT_W   = 64;

  localparam logic [HIDX_W-1:0] NO_INDEX = '1;

  // Request codes; code 3 is unused and falls to the default arm
  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_QUERY   = 2'd2
  } action_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  // Commands to the free stack
  typedef struct packed {
    logic rd;    // read the top entry (data registered, valid in the next cycle)
    logic pop;   // drop the top entry
    logic push;  // push push_idx
  } stk_cmd_t;

endpackage

`default_nettype wire

[rtl/generational_handle_allocator.sv]
// Top level of the generational handle allocator: request sequencer and slot table.
// Depends on gha_pkg and gha_stack.
`default_nettype none

// Hands out handles (slot index plus generation) over CAPACITY slots and
// checks or releases them. An allocate with a free slot passes the pop and
// execute states, any other request only the execute state; the input stays
// closed until the sequencer is idle again. The result word is registered as
// the execute state ends, later while the output register still holds an
// untaken word. The free stack memory is read first (allocate only), then the
// slot table memory, both with registered read data, and the write-back happens
// as the result is registered. A new request is taken once the previous one
// has written back, even while its result still waits at the output. No
// clearing pass follows reset: a high-water mark of slots ever allocated
// stands in for the reset contents of both memories, so requests are taken at once.
module generational_handle_allocator
  import gha_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // action[1:0], handle_index[17:2], handle_generation[49:18], zero pad
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // ok[0], out_index[16:1], out_generation[48:17], live_count[59:49], zero pad
  output logic [OUT_W-1:0]      m_axis_tdata
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t            state;
  state_t            state_next;
  stk_cmd_t          stk_cmd;
  logic [IDX_W-1:0]  popped;
  logic [CNT_W-1:0]  depth;
  logic [CNT_W-1:0]  hwm;

  action_t           in_act;
  logic [HIDX_W-1:0] in_idx;
  logic [GEN_W-1:0]  in_gen;
  logic              in_range;
  logic              accept;

  action_t           req_act;
  logic [IDX_W-1:0]  req_idx;
  logic [GEN_W-1:0]  req_gen;
  logic              req_in_range;

  logic [GEN_W:0]    slot_mem [CAPACITY];  // {live, generation}
  logic [GEN_W:0]    slot_rd;
  logic              slot_fresh;
  logic              slot_rd_en;
  logic [IDX_W-1:0]  slot_addr;
  logic              slot_wr_en;
  logic [GEN_W:0]    slot_wr_data;

  logic [GEN_W-1:0]  cur_gen;
  logic              cur_live;
  logic [GEN_W-1:0]  gen_inc;
  logic [GEN_W-1:0]  gen_next;
  logic              hit;
  logic              alloc_ok;
  logic              rel_ok;
  logic              do_exec;
  logic              res_ok;
  logic [HIDX_W-1:0] res_idx;
  logic [GEN_W-1:0]  res_gen;

  logic [CNT_W-1:0]  live_total;

  // Unpack the request word
  assign in_act   = action_t'(s_axis_tdata[ACT_W-1:0]);
  assign in_idx   = s_axis_tdata[ACT_W +: HIDX_W];
  assign in_gen   = s_axis_tdata[ACT_W + HIDX_W +: GEN_W];
  assign in_range = (in_idx < HIDX_W'(CAPACITY));

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign do_exec       = (state == S_EXEC) && (!m_axis_tvalid || m_axis_tready);

  // Sequence: stack read (allocate with a free slot only), slot read, then check and write back
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (in_act == ACT_ALLOC && depth != '0) ? S_POP : S_EXEC;
        end
      end
      S_POP:  state_next = S_EXEC;
      S_EXEC: begin
        if (do_exec) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the request; the popped slot replaces the index on allocate
  always_ff @(posedge clk) begin
    if (accept) begin
      req_act      <= in_act;
      req_idx      <= IDX_W'(in_idx);
      req_gen      <= in_gen;
      req_in_range <= in_range;
    end else if (state == S_POP) begin
      req_idx <= popped;
    end
  end

  // Slot table read address
  always_comb begin
    slot_rd_en = 1'b0;
    slot_addr  = IDX_W'(in_idx);
    if (state == S_POP) begin
      slot_rd_en = 1'b1;
      slot_addr  = popped;
    end else if (accept && in_range) begin
      slot_rd_en = 1'b1;
    end
  end

  // Slot table: slots at or above the high-water mark still hold reset contents
  always_ff @(posedge clk) begin
    if (slot_rd_en) begin
      slot_rd    <= slot_mem[slot_addr];
      slot_fresh <= (CNT_W'(slot_addr) >= hwm);
    end
    if (slot_wr_en) begin
      slot_mem[req_idx] <= slot_wr_data;
    end
  end

  assign cur_gen  = slot_fresh ? GEN_W'(1) : slot_rd[GEN_W-1:0];
  assign cur_live = !slot_fresh && slot_rd[GEN_W];
  assign gen_inc  = cur_gen + GEN_W'(1);
  assign gen_next = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
  assign hit      = (req_gen != '0) && req_in_range && cur_live && (cur_gen == req_gen);

  // Decide the outcome of the request
  always_comb begin
    alloc_ok = 1'b0;
    rel_ok   = 1'b0;
    res_ok   = 1'b0;
    res_idx  = NO_INDEX;
    res_gen  = '0;
    case (req_act)
      ACT_ALLOC: begin
        if (depth != '0) begin
          alloc_ok = 1'b1;
          res_ok   = 1'b1;
          res_idx  = HIDX_W'(req_idx);
          res_gen  = cur_gen;
        end
      end
      ACT_RELEASE: begin
        rel_ok = hit;
        res_ok = hit;
      end
      ACT_QUERY: res_ok = hit;
      default: res_ok = 1'b0;
    endcase
  end

  assign slot_wr_en   = do_exec && (alloc_ok || rel_ok);
  assign slot_wr_data = alloc_ok ? {1'b1, cur_gen} : {1'b0, gen_next};

  always_comb begin
    stk_cmd      = '0;
    stk_cmd.rd   = accept && (in_act == ACT_ALLOC) && (depth != '0);
    stk_cmd.pop  = do_exec && alloc_ok;
    stk_cmd.push = do_exec && rel_ok;
  end

  gha_stack #(
    .CAPACITY (CAPACITY)
  ) u_stack (
    .clk      (clk),
    .rst      (rst),
    .cmd      (stk_cmd),
    .push_idx (req_idx),
    .popped   (popped),
    .depth    (depth),
    .hwm      (hwm)
  );

  // Count live handles
  always_ff @(posedge clk) begin
    if (rst) begin
      live_total <= '0;
    end else if (do_exec && alloc_ok) begin
      live_total <= live_total + CNT_W'(1);
    end else if (do_exec && rel_ok) begin
      live_total <= live_total - CNT_W'(1);
    end
  end

  // Output register: load on write-back, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (do_exec) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_exec) begin
      m_axis_tdata <= {(OUT_W - 1 - HIDX_W - GEN_W - LIVE_W)'(0),
                       alloc_ok ? LIVE_W'(live_total + CNT_W'(1)) :
                       rel_ok   ? LIVE_W'(live_total - CNT_W'(1)) : LIVE_W'(live_total),
                       res_gen, res_idx, res_ok};
    end
  end

  // Every slot is either on the free stack or live
  assert property (@(posedge clk) disable iff (rst)
    (CNT_W + 1)'(depth) + (CNT_W + 1)'(live_total) == (CNT_W + 1)'(CAPACITY))
    else $error("free stack depth and live count disagree");

  // A granted allocation never hands out generation zero
  assert property (@(posedge clk) disable iff (rst)
    (do_exec && alloc_ok) |-> (cur_gen != '0))
    else $error("allocation returned generation zero");

  // No write-back while no request is in hand
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !slot_wr_en && !stk_cmd.pop && !stk_cmd.push)
    else $error("state update outside a request");

  // An accepted request is followed by work, never by another acceptance
  assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("request taken while another was in hand");

endmodule

`default_nettype wire

[rtl/gha_stack.sv]
// Free slot stack of the handle allocator: one synchronous memory plus a fill count and a low-water mark.
// Depends on gha_pkg.
`default_nettype none

module gha_stack
  import gha_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire stk_cmd_t                                  cmd,
  input  wire logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] push_idx,
  output logic      [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] popped,
  output logic      [$clog2(CAPACITY + 1)-1:0]           depth,
  output logic      [$clog2(CAPACITY + 1)-1:0]           hwm
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic [IDX_W-1:0] mem [CAPACITY];
  logic [CNT_W-1:0] free_top;
  logic [CNT_W-1:0] min_top;   // lowest depth ever reached; entries below it are untouched
  logic [IDX_W-1:0] rd_data;
  logic             rd_fresh;
  logic [IDX_W-1:0] rd_fresh_val;
  logic [CNT_W-1:0] top_less;

  assign top_less = free_top - CNT_W'(1);

  // Read the top entry; an untouched entry k still holds CAPACITY-1-k
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data      <= mem[top_less[IDX_W-1:0]];
      rd_fresh     <= (free_top == min_top);
      rd_fresh_val <= IDX_W'(CAP_C - free_top);
    end
    if (cmd.push) begin
      mem[free_top[IDX_W-1:0]] <= push_idx;
    end
  end

  assign popped = rd_fresh ? rd_fresh_val : rd_data;

  // Advance the stack pointer and the low-water mark
  always_ff @(posedge clk) begin
    if (rst) begin
      free_top <= CAP_C;
      min_top  <= CAP_C;
    end else if (cmd.pop) begin
      free_top <= top_less;
      if (free_top == min_top) begin
        min_top <= top_less;
      end
    end else if (cmd.push) begin
      free_top <= free_top + CNT_W'(1);
    end
  end

  assign depth = free_top;
  assign hwm   = CAP_C - min_top;

endmodule

`default_nettype wire
